// ----- rtl/sbg_pkg.sv -----
// ----------------------------------------------------------------------------
// sbg_pkg
// shared types and constants for the single button gate model
// ----------------------------------------------------------------------------
`default_nettype none

package sbg_pkg;

  // default widths of the position and qualify timer datapaths
  localparam int POS_BITS_DEF   = 20;
  localparam int TIMER_BITS_DEF = 16;

  // fixed widths of the port words
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int MIN_PULSE_W   = 16;
  localparam int TRAVEL_W      = 20;
  localparam int GATE_POS_W    = 20;
  localparam int MOTION_W      = 2;

  // register reset values
  localparam int MIN_PULSE_RST = 250;
  localparam int TRAVEL_RST    = 10000;
  localparam int MARGIN_RST    = 100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIN_PULSE = 2'd0,
    CFG_TRAVEL    = 2'd1,
    CFG_MARGIN    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE_LO = 2'd0,
    PH_RISING  = 2'd1,
    PH_IDLE_HI = 2'd2,
    PH_FALLING = 2'd3
  } qphase_t;

  typedef enum logic [MOTION_W-1:0] {
    DIR_STOP  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  // control state that does not depend on the datapath widths
  typedef struct packed {
    qphase_t phase;
    logic    armed;
    dir_t    dir;
    logic    last_open;
  } ctl_t;

  // contact report of one word
  typedef struct packed {
    logic report;
    logic closed;
  } rep_t;

endpackage

`default_nettype wire

// ----- rtl/single_button_gate_model.sv -----
// ----------------------------------------------------------------------------
// single_button_gate_model
// one-button gate: press/release qualifier, travel counter, contact reports
// ----------------------------------------------------------------------------
// a word accepted goes through the input register, then the result register
//   after one pass of the step logic
// throughput: 1 word per cycle, limited only by result back-pressure
// reset: synchronous active-low rst_n; gate closed and stopped, qualifier
//   idle low, registers back to 250 / 10000 / 100, no clearing pass
`default_nettype none

module single_button_gate_model import sbg_pkg::*; #(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  input  wire logic                   in_ctl_level,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_contact_report,
  output logic                        out_contact_closed,
  output logic [GATE_POS_W-1:0]       out_gate_position,
  output logic [MOTION_W-1:0]         out_motion,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [TIMER_BITS-1:0] min_pulse;
  logic [POS_BITS-1:0]   travel;
  logic [POS_BITS-1:0]   margin;

  assign cfg_ready = 1'b1;

  sbg_cfg #(
    .POS_BITS   (POS_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .min_pulse (min_pulse),
    .travel    (travel),
    .margin    (margin)
  );

  // input register
  logic in_valid_r;
  logic cmd_r;
  logic level_r;
  logic advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_command;
      level_r <= in_ctl_level;
    end
  end

  // gate state
  ctl_t                  ctl_r, ctl_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  rep_t                  rep_nxt;
  logic                  step_en;

  assign step_en = in_valid_r && advance;

  sbg_step #(
    .POS_BITS   (POS_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .is_tick   (cmd_r),
    .level     (level_r),
    .ctl_cur   (ctl_r),
    .timer_cur (timer_r),
    .pos_cur   (pos_r),
    .min_pulse (min_pulse),
    .travel    (travel),
    .margin    (margin),
    .ctl_new   (ctl_nxt),
    .timer_new (timer_nxt),
    .pos_new   (pos_nxt),
    .rep       (rep_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '{phase: PH_IDLE_LO, armed: 1'b0, dir: DIR_STOP, last_open: 1'b0};
      timer_r <= '0;
      pos_r   <= '0;
    end else if (step_en) begin
      ctl_r   <= ctl_nxt;
      timer_r <= timer_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // result register
  logic                  out_valid_r;
  rep_t                  out_rep_r;
  logic [GATE_POS_W-1:0] out_pos_r;
  dir_t                  out_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_rep_r <= rep_nxt;
      out_pos_r <= GATE_POS_W'(pos_nxt);
      out_dir_r <= ctl_nxt.dir;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_contact_report = out_rep_r.report;
  assign out_contact_closed = out_rep_r.closed;
  assign out_gate_position  = out_pos_r;
  assign out_motion         = MOTION_W'(out_dir_r);

  // assertions
  a_closed_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_contact_report || !out_contact_closed))
    else $error("contact closed flagged without a report");

  a_open_report_opening: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_contact_report && !out_contact_closed) |-> (out_dir_r == DIR_OPEN))
    else $error("open contact reported while not opening");

  a_armed_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.armed |-> (ctl_r.phase == PH_RISING || ctl_r.phase == PH_FALLING))
    else $error("qualify timer armed in an idle phase");

  a_stalled_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(ctl_r) && $stable(pos_r)))
    else $error("word or state lost while result stalled");

endmodule

`default_nettype wire

// ----- rtl/sbg_cfg.sv -----
// ----------------------------------------------------------------------------
// sbg_cfg
// configuration registers: minimum pulse, travel length and closed margin
// ----------------------------------------------------------------------------
`default_nettype none

module sbg_cfg import sbg_pkg::*; #(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output logic [TIMER_BITS-1:0]       min_pulse,
  output logic [POS_BITS-1:0]         travel,
  output logic [POS_BITS-1:0]         margin
);

  logic [TIMER_BITS-1:0] min_pulse_r, min_pulse_nxt;
  logic [POS_BITS-1:0]   travel_r, travel_nxt;
  logic [POS_BITS-1:0]   margin_r, margin_nxt;

  always_comb begin
    min_pulse_nxt = min_pulse_r;
    travel_nxt    = travel_r;
    margin_nxt    = margin_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_MIN_PULSE: min_pulse_nxt = TIMER_BITS'(wr_data[MIN_PULSE_W-1:0]);
        CFG_TRAVEL:    travel_nxt    = POS_BITS'(wr_data[TRAVEL_W-1:0]);
        CFG_MARGIN:    margin_nxt    = POS_BITS'(wr_data[TRAVEL_W-1:0]);
        default: ;     // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= TIMER_BITS'(MIN_PULSE_RST);
      travel_r    <= POS_BITS'(TRAVEL_RST);
      margin_r    <= POS_BITS'(MARGIN_RST);
    end else begin
      min_pulse_r <= min_pulse_nxt;
      travel_r    <= travel_nxt;
      margin_r    <= margin_nxt;
    end
  end

  assign min_pulse = min_pulse_r;
  assign travel    = travel_r;
  assign margin    = margin_r;

endmodule

`default_nettype wire

// ----- rtl/sbg_step.sv -----
// ----------------------------------------------------------------------------
// sbg_step
// next state and contact report for one word: tick or level sample
// ----------------------------------------------------------------------------
`default_nettype none

module sbg_step import sbg_pkg::*; #(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                  is_tick,
  input  wire logic                  level,
  input  wire ctl_t                  ctl_cur,
  input  wire logic [TIMER_BITS-1:0] timer_cur,
  input  wire logic [POS_BITS-1:0]   pos_cur,
  input  wire logic [TIMER_BITS-1:0] min_pulse,
  input  wire logic [POS_BITS-1:0]   travel,
  input  wire logic [POS_BITS-1:0]   margin,
  output ctl_t                       ctl_new,
  output logic [TIMER_BITS-1:0]      timer_new,
  output logic [POS_BITS-1:0]        pos_new,
  output rep_t                       rep
);

  always_comb begin
    logic at_end;
    at_end    = 1'b0;
    ctl_new   = ctl_cur;
    timer_new = timer_cur;
    pos_new   = pos_cur;
    rep       = '0;

    if (is_tick) begin
      // motion first
      if (ctl_new.dir == DIR_OPEN) begin
        if (pos_new < travel) pos_new = pos_new + POS_BITS'(1);
        if (pos_new >= travel) begin
          pos_new = travel;
          at_end  = 1'b1;
        end
      end else if (ctl_new.dir == DIR_CLOSE) begin
        if (pos_new != '0) pos_new = pos_new - POS_BITS'(1);
        if (pos_new == '0) at_end = 1'b1;
      end
      if (at_end) begin
        if (ctl_new.dir != DIR_STOP && pos_new <= margin) rep = '{report: 1'b1, closed: 1'b1};
        ctl_new.dir = DIR_STOP;
        // end of travel drops a pending press
        if (ctl_new.phase == PH_RISING) ctl_new.armed = 1'b0;
      end

      // then the qualify timer
      if (ctl_new.armed) begin
        if (timer_new <= TIMER_BITS'(1)) begin
          timer_new     = '0;
          ctl_new.armed = 1'b0;
          if (ctl_new.phase == PH_RISING) begin
            ctl_new.phase = PH_IDLE_HI;
            if (ctl_new.dir != DIR_STOP) begin
              if (pos_new <= margin) rep = '{report: 1'b1, closed: 1'b1};
              ctl_new.dir = DIR_STOP;
            end else if (ctl_new.last_open) begin
              ctl_new.dir       = DIR_CLOSE;
              ctl_new.last_open = 1'b0;
            end else begin
              ctl_new.dir       = DIR_OPEN;
              ctl_new.last_open = 1'b1;
              if (pos_new <= margin) rep = '{report: 1'b1, closed: 1'b0};
            end
          end else if (ctl_new.phase == PH_FALLING) begin
            ctl_new.phase = PH_IDLE_LO;
          end
        end else begin
          timer_new = timer_new - TIMER_BITS'(1);
        end
      end
    end else begin
      case (ctl_cur.phase)
        PH_IDLE_LO: begin
          if (level) begin
            ctl_new.phase = PH_RISING;
            ctl_new.armed = 1'b1;
            timer_new     = min_pulse;
          end
        end
        PH_RISING: begin
          if (!level) begin
            ctl_new.phase = PH_IDLE_LO;
            ctl_new.armed = 1'b0;
          end
        end
        PH_IDLE_HI: begin
          if (!level) begin
            ctl_new.phase = PH_FALLING;
            ctl_new.armed = 1'b1;
            timer_new     = min_pulse;
          end
        end
        PH_FALLING: begin
          if (level) begin
            ctl_new.phase = PH_IDLE_HI;
            ctl_new.armed = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the one-button gate against a cycle-free predictor of its qualifier,
// travel counter and contact reports; directed words first, then random
// press/release sequences over several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sbg_pkg::*;

  localparam logic CMD_SAMPLE     = 1'b0;
  localparam logic CMD_TICK       = 1'b1;
  localparam int   WATCHDOG_LIMIT = 1000;
  localparam int   MAX_REPORTS    = 10;

  typedef struct packed {
    logic                  report;
    logic                  closed;
    logic [GATE_POS_W-1:0] pos;
    dir_t                  motion;
  } gate_word_t;

  typedef struct packed {
    logic                   setup;
    logic                   cmd;
    logic                   lvl;
    logic                   typed;
    gate_word_t             exp;
    logic [MIN_PULSE_W-1:0] min_p;
    logic [TRAVEL_W-1:0]    travel;
    logic [TRAVEL_W-1:0]    margin;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_command;
  logic                   in_ctl_level;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_contact_report;
  logic                   out_contact_closed;
  logic [GATE_POS_W-1:0]  out_gate_position;
  logic [MOTION_W-1:0]    out_motion;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  single_button_gate_model dut (.*);

  // predicted gate state and register copies
  qphase_t                g_phase;
  logic [MIN_PULSE_W-1:0] g_timer;
  logic                   g_armed;
  logic [GATE_POS_W-1:0]  g_pos;
  dir_t                   g_dir;
  logic                   g_last_open;
  logic [MIN_PULSE_W-1:0] g_min;
  logic [TRAVEL_W-1:0]    g_travel;
  logic [TRAVEL_W-1:0]    g_margin;

  gate_word_t pending_results[$];
  logic       row_typed;
  gate_word_t row_exp;
  int         mismatches;
  int         words_sent;
  int         idle_cycles;
  bit         no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stopping the gate reports closed only if it was moving and ends low enough
  function automatic logic halt_closes();
    logic hit;
    hit = (g_dir != DIR_STOP) && (g_pos <= g_margin);
    g_dir = DIR_STOP;
    return hit;
  endfunction

  task automatic predict_word(input logic cmd, input logic lvl, output gate_word_t res);
    logic at_end;
    logic rep;
    logic cl;
    at_end = 1'b0;
    rep    = 1'b0;
    cl     = 1'b0;
    if (cmd == CMD_TICK) begin
      // motion first, then the qualify timer
      if (g_dir == DIR_OPEN) begin
        if (g_pos < g_travel) g_pos = g_pos + 1'b1;
        if (g_pos >= g_travel) begin
          g_pos  = g_travel;
          at_end = 1'b1;
        end
      end else if (g_dir == DIR_CLOSE) begin
        if (g_pos > 0) g_pos = g_pos - 1'b1;
        if (g_pos == 0) at_end = 1'b1;
      end
      if (at_end) begin
        if (halt_closes()) begin
          rep = 1'b1;
          cl  = 1'b1;
        end
        // end of travel drops a press still being qualified
        if (g_phase == PH_RISING) g_armed = 1'b0;
      end
      if (g_armed) begin
        if (g_timer <= 1) begin
          g_timer = '0;
          g_armed = 1'b0;
          if (g_phase == PH_RISING) begin
            g_phase = PH_IDLE_HI;
            if (g_dir != DIR_STOP) begin
              if (halt_closes()) begin
                rep = 1'b1;
                cl  = 1'b1;
              end
            end else if (g_last_open) begin
              g_dir       = DIR_CLOSE;
              g_last_open = 1'b0;
            end else begin
              g_dir       = DIR_OPEN;
              g_last_open = 1'b1;
              if (g_pos <= g_margin) begin
                rep = 1'b1;
                cl  = 1'b0;
              end
            end
          end else if (g_phase == PH_FALLING) begin
            g_phase = PH_IDLE_LO;
          end
        end else begin
          g_timer = g_timer - 1'b1;
        end
      end
    end else begin
      case (g_phase)
        PH_IDLE_LO: if (lvl) begin
          g_phase = PH_RISING;
          g_timer = g_min;
          g_armed = 1'b1;
        end
        PH_RISING: if (!lvl) begin
          g_phase = PH_IDLE_LO;
          g_armed = 1'b0;
        end
        PH_IDLE_HI: if (!lvl) begin
          g_phase = PH_FALLING;
          g_timer = g_min;
          g_armed = 1'b1;
        end
        default: if (lvl) begin
          g_phase = PH_IDLE_HI;
          g_armed = 1'b0;
        end
      endcase
    end
    res = '{rep, cl, g_pos, g_dir};
  endtask

  task automatic report_miss(input string tag, input gate_word_t want, input gate_word_t got);
    if (mismatches < MAX_REPORTS)
      $display("%0t %s: expected report=%0b closed=%0b pos=%0d motion=%0d",
               $time, tag, want.report, want.closed, want.pos, want.motion,
               " / got report=%0b closed=%0b pos=%0d motion=%0d",
               got.report, got.closed, got.pos, got.motion);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    gate_word_t want;
    gate_word_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_word(in_command, in_ctl_level, want);
        pending_results.push_back(row_typed ? row_exp : want);
      end
      if (out_valid && out_ready) begin
        got = '{out_contact_report, out_contact_closed, out_gate_position,
                dir_t'(out_motion)};
        if (pending_results.size() == 0) begin
          report_miss("unexpected word", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.report !== want.report || got.closed !== want.closed ||
              got.pos !== want.pos || got.motion !== want.motion)
            report_miss("mismatch", want, got);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stalls before each word, none in calm stretches
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // called at a falling edge; leaves valid high so a following word can follow on
  task automatic send_word(input logic cmd, input logic lvl, input logic typed,
                           input gate_word_t exp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_ctl_level <= lvl;
    row_typed    <= typed;
    row_exp      <= exp;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_PULSE: g_min    = data[MIN_PULSE_W-1:0];
      CFG_TRAVEL:    g_travel = data[TRAVEL_W-1:0];
      default:       g_margin = data[TRAVEL_W-1:0];
    endcase
    @(negedge clk);
  endtask

  // registers change only once the block has drained; upper data bits are junk
  task automatic set_gate(input logic [MIN_PULSE_W-1:0] min_p,
                          input logic [TRAVEL_W-1:0] travel,
                          input logic [TRAVEL_W-1:0] margin);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_MIN_PULSE, {16'($urandom()), min_p});
    write_reg(CFG_TRAVEL, {12'($urandom()), travel});
    write_reg(CFG_MARGIN, {12'($urandom()), margin});
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t word_row(input logic cmd, input logic lvl);
    plan_row_t r;
    r     = '0;
    r.cmd = cmd;
    r.lvl = lvl;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic cmd, input logic lvl, input logic rep,
                                          input logic closed,
                                          input logic [GATE_POS_W-1:0] pos,
                                          input dir_t motion);
    plan_row_t r;
    r       = word_row(cmd, lvl);
    r.typed = 1'b1;
    r.exp   = '{rep, closed, pos, motion};
    return r;
  endfunction

  function automatic plan_row_t setup_row(input logic [MIN_PULSE_W-1:0] min_p,
                                          input logic [TRAVEL_W-1:0] travel,
                                          input logic [TRAVEL_W-1:0] margin);
    plan_row_t r;
    r        = '0;
    r.setup  = 1'b1;
    r.min_p  = min_p;
    r.travel = travel;
    r.margin = margin;
    return r;
  endfunction

  // press and release sequences around the qualifying length, plus noise
  task automatic run_random(input int n_words);
    int stop_at;
    int hold;
    int sel;
    int span;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        for (int half = 0; half < 2; half++) begin
          send_word(CMD_SAMPLE, half == 0, 1'b0, '0);
          if ($urandom_range(0, 7) == 0) send_word(CMD_SAMPLE, half == 0, 1'b0, '0);
          // now and then too short, so the press or release is broken off
          hold = ($urandom_range(0, 4) == 0) ? $urandom_range(0, int'(g_min))
                                              : int'(g_min) + $urandom_range(0, 2);
          if (hold > 30) hold = $urandom_range(0, 30);
          repeat (hold) send_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        span = (g_travel > 30) ? 30 : int'(g_travel) + 2;
        repeat ($urandom_range(0, span))
          send_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 6))
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 10))
          send_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    plan_row_t directed[$];
    int        tr;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_SAMPLE;
    in_ctl_level = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MIN_PULSE;
    cfg_data     = '0;
    row_typed    = 1'b0;
    row_exp      = '0;
    mismatches   = 0;
    words_sent   = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    g_phase      = PH_IDLE_LO;
    g_timer      = '0;
    g_armed      = 1'b0;
    g_pos        = '0;
    g_dir        = DIR_STOP;
    g_last_open  = 1'b0;
    g_min        = MIN_PULSE_W'(MIN_PULSE_RST);
    g_travel     = TRAVEL_W'(TRAVEL_RST);
    g_margin     = TRAVEL_W'(MARGIN_RST);

    // reset settings: nothing qualifies within a few words
    directed.push_back(typed_row(CMD_TICK, 1'b1, 1'b0, 1'b0, '0, DIR_STOP));
    directed.push_back(typed_row(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, '0, DIR_STOP));
    directed.push_back(typed_row(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, '0, DIR_STOP));
    directed.push_back(typed_row(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, '0, DIR_STOP));
    // zero pulse length and zero travel, widest margin
    directed.push_back(setup_row(16'd0, 20'd0, 20'hFFFFF));
    directed.push_back(word_row(CMD_SAMPLE, 1'b1));
    directed.push_back(typed_row(CMD_TICK, 1'b0, 1'b1, 1'b0, '0, DIR_OPEN));
    directed.push_back(typed_row(CMD_TICK, 1'b0, 1'b1, 1'b1, '0, DIR_STOP));
    directed.push_back(word_row(CMD_SAMPLE, 1'b0));
    directed.push_back(word_row(CMD_TICK, 1'b1));
    directed.push_back(word_row(CMD_SAMPLE, 1'b1));
    directed.push_back(word_row(CMD_TICK, 1'b0));
    // closing from the closed end stops at once
    directed.push_back(typed_row(CMD_TICK, 1'b1, 1'b1, 1'b1, '0, DIR_STOP));
    // short travel: a release, then a press that qualifies and starts the gate opening
    directed.push_back(setup_row(16'd2, 20'd3, 20'd0));
    directed.push_back(word_row(CMD_SAMPLE, 1'b1));
    directed.push_back(word_row(CMD_TICK, 1'b0));
    directed.push_back(word_row(CMD_TICK, 1'b1));
    directed.push_back(word_row(CMD_SAMPLE, 1'b0));
    directed.push_back(word_row(CMD_TICK, 1'b0));
    directed.push_back(word_row(CMD_TICK, 1'b1));
    directed.push_back(word_row(CMD_SAMPLE, 1'b1));
    directed.push_back(word_row(CMD_TICK, 1'b0));
    directed.push_back(word_row(CMD_TICK, 1'b0));
    directed.push_back(word_row(CMD_SAMPLE, 1'b0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].setup)
        set_gate(directed[i].min_p, directed[i].travel, directed[i].margin);
      else
        send_word(directed[i].cmd, directed[i].lvl, directed[i].typed, directed[i].exp);
    end

    tr = $urandom_range(1, 24);
    set_gate(16'($urandom_range(1, 3)), 20'(tr), 20'($urandom_range(0, tr)));
    run_random(400);
    set_gate(16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    run_random(80);
    set_gate(16'd1, 20'd1, 20'd0);
    run_random(150);
    set_gate(16'($urandom_range(1, 4)), 20'($urandom_range(1, 40)),
             20'($urandom_range(0, 60)));
    run_random(400);
    set_gate(16'($urandom_range(0, 2)), 20'($urandom_range(0, 8)),
             ($urandom_range(0, 1) == 0) ? 20'($urandom_range(0, 10)) : 20'hFFFFF);
    run_random(300);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sbg_pkg.sv
rtl/sbg_cfg.sv
rtl/sbg_step.sv
rtl/single_button_gate_model.sv
verif/tb_top.sv
